// ----- src/pds_pkg.sv -----
// Shared types, codes and helpers for the publish due scheduler.
`timescale 1ns / 1ps

package pds_pkg;

  localparam int TIME_BITS = 32;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  localparam tstamp_t TIME_MSB = tstamp_t'(1) << (TIME_BITS - 1);

  localparam logic [31:0] RETRY_RESET = 32'd5000;
  localparam logic [31:0] STATE_INT_RESET = 32'd60000;
  localparam logic [31:0] TELEM_INT_RESET = 32'd10000;

  typedef enum logic [2:0] {
    CMD_QUERY       = 3'd0,
    CMD_CONNECT     = 3'd1,
    CMD_DISCONNECT  = 3'd2,
    CMD_STATE_CHG   = 3'd3,
    CMD_AVAIL_TRY   = 3'd4,
    CMD_STATE_TRY   = 3'd5,
    CMD_TELEM_TRY   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RETRY     = 2'd0,
    REG_STATE_INT = 2'd1,
    REG_TELEM_INT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] retry_delay_ms;
    logic [31:0] state_interval_ms;
    logic [31:0] telem_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic        success;
  } item_t;

  typedef struct packed {
    logic availability_due;
    logic state_due;
    logic telemetry_due;
  } result_t;

  // Fit a 32-bit value into the time width, zero extending or truncating.
  function automatic tstamp_t to_time(input logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[TIME_BITS-1:0];
  endfunction

  // A due time of now + d is reached at now exactly when d is zero or above half range.
  function automatic logic offset_reached(input tstamp_t d);
    return (d == '0) || (d > TIME_MSB);
  endfunction

endpackage

// ----- src/publish_due_scheduler.sv -----
// Top level of the publish due scheduler: input register, config bank, core and result register.
// An accepted item is held in the input register until the core applies it, and its
// result is loaded into the result register, from which the result item is offered.
// Throughput: one item per cycle; the input register hands over as soon as the
// result register is empty or being taken, so state updates once per item.
// Reset: synchronous active-low rst_n clears the link, pending and sent flags and
// the due times, and loads the interval registers with their default values.
`timescale 1ns / 1ps

module publish_due_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] now_ms, [32] success, [39:33] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] availability_due, [1] state_due,
                                  // [2] telemetry_due, [7:3] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pds_pkg::cfg_t    cfg;
  pds_pkg::item_t   item_r;
  pds_pkg::result_t res;
  pds_pkg::result_t res_r;
  logic             item_valid_r;
  logic             out_valid_r;
  logic             advance;
  logic             in_take;

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  pds_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pds_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .apply (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command <= in_tuser;
      item_r.now_ms  <= in_tdata[31:0];
      item_r.success <= in_tdata[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.telemetry_due, res_r.state_due, res_r.availability_due};

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after handover");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !advance) |=> (item_valid_r && $stable(item_r)))
    else $error("pending item lost while output stalled");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are blocked");

endmodule

// ----- src/pds_cfg_regs.sv -----
// Configuration register bank for the publish due scheduler.
`timescale 1ns / 1ps

module pds_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output pds_pkg::cfg_t    cfg
);

  pds_pkg::cfg_t cfg_r;
  pds_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pds_pkg::REG_RETRY:     cfg_nxt.retry_delay_ms = cfg_data;
        pds_pkg::REG_STATE_INT: cfg_nxt.state_interval_ms = cfg_data;
        pds_pkg::REG_TELEM_INT: cfg_nxt.telem_period_ms = cfg_data;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_delay_ms    <= pds_pkg::RETRY_RESET;
      cfg_r.state_interval_ms <= pds_pkg::STATE_INT_RESET;
      cfg_r.telem_period_ms   <= pds_pkg::TELEM_INT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- src/pds_core.sv -----
// Schedule state, event update and due flag evaluation.
`timescale 1ns / 1ps

module pds_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               apply,
  input  pds_pkg::item_t     item,
  input  pds_pkg::cfg_t      cfg,
  output pds_pkg::result_t   res
);

  logic             link_up_r, link_up_nxt;
  logic             avail_pend_r, avail_pend_nxt;
  logic             state_pend_r, state_pend_nxt;
  logic             sent_once_r, sent_once_nxt;
  pds_pkg::tstamp_t avail_due_r, avail_due_nxt;
  pds_pkg::tstamp_t state_due_r, state_due_nxt;
  pds_pkg::tstamp_t last_state_r, last_state_nxt;
  pds_pkg::tstamp_t telem_due_r, telem_due_nxt;

  pds_pkg::tstamp_t now;
  pds_pkg::tstamp_t d_retry;
  pds_pkg::tstamp_t d_telem;
  pds_pkg::tstamp_t sum_retry;
  pds_pkg::tstamp_t sum_telem;
  pds_pkg::tstamp_t diff_avail;
  pds_pkg::tstamp_t diff_state;
  pds_pkg::tstamp_t diff_telem;
  pds_pkg::tstamp_t elapsed;
  logic             a_reach, s_reach, t_reach;
  logic             r_retry, r_telem;
  logic             elapsed_ge;

  assign now        = pds_pkg::to_time(item.now_ms);
  assign d_retry    = pds_pkg::to_time(cfg.retry_delay_ms);
  assign d_telem    = pds_pkg::to_time(cfg.telem_period_ms);
  assign sum_retry  = now + d_retry;
  assign sum_telem  = now + d_telem;
  assign diff_avail = now - avail_due_r;
  assign diff_state = now - state_due_r;
  assign diff_telem = now - telem_due_r;
  assign r_retry    = pds_pkg::offset_reached(d_retry);
  assign r_telem    = pds_pkg::offset_reached(d_telem);

  always_comb begin
    link_up_nxt    = link_up_r;
    avail_pend_nxt = avail_pend_r;
    state_pend_nxt = state_pend_r;
    sent_once_nxt  = sent_once_r;
    avail_due_nxt  = avail_due_r;
    state_due_nxt  = state_due_r;
    last_state_nxt = last_state_r;
    telem_due_nxt  = telem_due_r;
    a_reach        = !diff_avail[pds_pkg::TIME_BITS-1];
    s_reach        = !diff_state[pds_pkg::TIME_BITS-1];
    t_reach        = !diff_telem[pds_pkg::TIME_BITS-1];
    elapsed        = now - last_state_r;
    unique case (item.command)
      pds_pkg::CMD_CONNECT: begin
        link_up_nxt    = 1'b1;
        avail_pend_nxt = 1'b1;
        state_pend_nxt = 1'b1;
        avail_due_nxt  = now;
        state_due_nxt  = now;
        a_reach        = 1'b1;
        s_reach        = 1'b1;
      end
      pds_pkg::CMD_DISCONNECT: begin
        link_up_nxt = 1'b0;
      end
      pds_pkg::CMD_STATE_CHG: begin
        state_pend_nxt = 1'b1;
        state_due_nxt  = now;
        s_reach        = 1'b1;
      end
      pds_pkg::CMD_AVAIL_TRY: begin
        avail_pend_nxt = !item.success;
        if (!item.success) begin
          avail_due_nxt = sum_retry;
          a_reach       = r_retry;
        end
      end
      pds_pkg::CMD_STATE_TRY: begin
        state_pend_nxt = !item.success;
        if (item.success) begin
          sent_once_nxt  = 1'b1;
          last_state_nxt = now;
          elapsed        = '0;
        end else begin
          state_due_nxt = sum_retry;
          s_reach       = r_retry;
        end
      end
      pds_pkg::CMD_TELEM_TRY: begin
        telem_due_nxt = item.success ? sum_telem : sum_retry;
        t_reach       = item.success ? r_telem : r_retry;
      end
      default: begin
        link_up_nxt = link_up_r;
      end
    endcase
  end

  assign elapsed_ge = 64'(elapsed) >= 64'(cfg.state_interval_ms);

  assign res.availability_due = link_up_nxt && avail_pend_nxt && a_reach;
  assign res.state_due        = link_up_nxt &&
                                (state_pend_nxt ? s_reach : (sent_once_nxt && elapsed_ge));
  assign res.telemetry_due    = link_up_nxt && t_reach;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_r    <= 1'b0;
      avail_pend_r <= 1'b0;
      state_pend_r <= 1'b0;
      sent_once_r  <= 1'b0;
      avail_due_r  <= '0;
      state_due_r  <= '0;
      last_state_r <= '0;
      telem_due_r  <= '0;
    end else if (apply) begin
      link_up_r    <= link_up_nxt;
      avail_pend_r <= avail_pend_nxt;
      state_pend_r <= state_pend_nxt;
      sent_once_r  <= sent_once_nxt;
      avail_due_r  <= avail_due_nxt;
      state_due_r  <= state_due_nxt;
      last_state_r <= last_state_nxt;
      telem_due_r  <= telem_due_nxt;
    end
  end

  a_flags_need_link: assert property (@(posedge clk) disable iff (!rst_n)
    (res.availability_due || res.state_due || res.telemetry_due) |-> link_up_nxt)
    else $error("due flag raised with link down");

  a_connect_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (apply && item.command == pds_pkg::CMD_CONNECT) |=>
      (link_up_r && avail_pend_r && state_pend_r))
    else $error("connect did not raise link and pending flags");

  a_state_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (apply && item.command == pds_pkg::CMD_STATE_TRY && item.success) |=>
      (sent_once_r && !state_pend_r && last_state_r == $past(now)))
    else $error("successful state publish not recorded");

endmodule
